// ===== rtl/core/pip_pkg.sv =====
// Shared constants and codes for the point-in-polygon test block.
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_SHORT = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_t;

endpackage

// ===== rtl/core/pip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/point_in_polygon_test.sv =====
// Point-in-polygon test over a vertex table held in RAM.
//
//  channel  dir  payload                               meaning
//  s_axis   in   tuser: operation; tdata: point_x,y    clear / append vertex / query point
//  m_axis   out  tdata: inside_res, convex; tuser: st  one result per request
//
// Clear, append and unused codes go from acceptance straight to the finish state.
// Query with n >= 3 vertices: the single RAM read port streams n + 2 vertices for the
// convexity pass and n + 1 for the test pass, each followed by a drain of the
// cross-product pipeline.
// rst is synchronous and empties the table; RAM contents are not cleared.
// A new request is taken as soon as the previous one has its result in the output
// register; a stalled output holds the block in its final state until taken.
module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: point_x [COORD_BITS-1:0], point_y [2*COORD_BITS-1:COORD_BITS], zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // tuser: operation [1:0]
  input  logic [OP_W-1:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: inside_res [0], convex [1], zero pad [7:2]
  output logic [7:0]                             m_axis_tdata,
  // tuser: status [1:0]
  output logic [STATUS_W-1:0]                    m_axis_tuser
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int CW  = $clog2(MAX_VERTICES + 3);
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int WW  = NW + 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CONV   = 4'b0010,
    ST_TEST   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic [NW-1:0] cnt;
  logic          accept;
  op_t           op_in;
  logic signed [COORD_BITS-1:0] in_x, in_y;

  // query point
  logic signed [COORD_BITS-1:0] px, py;

  // read sequencer
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] issue_left;
  logic [CW-1:0] k;
  logic          rd_en;
  logic          rd_valid;
  logic [2*COORD_BITS-1:0] rd_data;
  logic [AW-1:0] last_addr;

  // vertex window: w1 older, w2 newer
  logic signed [COORD_BITS-1:0] w1x, w1y, w2x, w2y;
  logic signed [COORD_BITS-1:0] nx, ny;
  logic signed [DW-1:0] ax, ay, bx, by;
  logic [CW-1:0] k_need;
  logic          s1_take;
  logic          crosses;

  logic                 s1_valid, s1_first, s1_cross;
  logic signed [DW-1:0] s1_ax, s1_ay, s1_bx, s1_by;
  logic                 s2_valid, s2_first, s2_cross;
  logic signed [PW-1:0] s2_l, s2_r;
  logic                 sg_pos, sg_neg;
  logic                 drained;

  logic          s0_pos, s0_neg;
  logic          fail;
  logic          convex_r;
  logic signed [WW-1:0] wn;

  logic          res_inside, res_convex;
  status_t       res_status;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op_in         = op_t'(s_axis_tuser);
  assign in_x          = s_axis_tdata[COORD_BITS-1:0];
  assign in_y          = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

  assign rd_en     = ((state == ST_CONV) || (state == ST_TEST)) && (issue_left != '0);
  assign last_addr = AW'(cnt - NW'(1));
  assign drained   = (issue_left == '0) && !rd_valid && !s1_valid && !s2_valid;

  pip_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk     (clk),
    .wr_en   (accept && (op_in == OP_APPEND) && (cnt < NW'(MAX_VERTICES))),
    .wr_addr (cnt[AW-1:0]),
    .wr_data ({in_y, in_x}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign nx = rd_data[COORD_BITS-1:0];
  assign ny = rd_data[2*COORD_BITS-1:COORD_BITS];

  // operand generation for corner, edge-side and crossing tests
  always_comb begin
    priority if (state == ST_CONV) begin
      ax = DW'(w2x) - DW'(w1x);
      ay = DW'(w2y) - DW'(w1y);
      bx = DW'(nx) - DW'(w2x);
      by = DW'(ny) - DW'(w2y);
    end else if (convex_r) begin
      ax = DW'(nx) - DW'(w2x);
      ay = DW'(ny) - DW'(w2y);
      bx = DW'(px) - DW'(w2x);
      by = DW'(py) - DW'(w2y);
    end else begin
      ax = DW'(w2x) - DW'(px);
      ay = DW'(w2y) - DW'(py);
      bx = DW'(nx) - DW'(px);
      by = DW'(ny) - DW'(py);
    end
  end

  assign crosses = ((ax[DW-1] || (ax == '0)) && !bx[DW-1]) ||
                   (!ax[DW-1] && (bx[DW-1] || (bx == '0)));
  assign k_need  = (state == ST_CONV) ? CW'(2) : CW'(1);
  assign s1_take = rd_valid && (k >= k_need);

  assign sg_pos = (s2_l > s2_r);
  assign sg_neg = (s2_l < s2_r);

  // datapath registers
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      w1x <= w2x;
      w1y <= w2y;
      w2x <= nx;
      w2y <= ny;
    end
    s1_ax    <= ax;
    s1_ay    <= ay;
    s1_bx    <= bx;
    s1_by    <= by;
    s1_first <= (k == k_need);
    s1_cross <= crosses;
    s2_l     <= s1_ax * s1_by;
    s2_r     <= s1_ay * s1_bx;
    s2_first <= s1_first;
    s2_cross <= s1_cross;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      issue_left    <= '0;
      k             <= '0;
      rd_valid      <= 1'b0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      res_inside    <= 1'b0;
      res_convex    <= 1'b0;
      res_status    <= STATUS_OK;
      rd_addr       <= '0;
      s0_pos        <= 1'b0;
      s0_neg        <= 1'b0;
      fail          <= 1'b0;
      convex_r      <= 1'b0;
      wn            <= '0;
      px            <= '0;
      py            <= '0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= STATUS_OK;
    end else begin
      rd_valid <= rd_en;
      s1_valid <= s1_take;
      s2_valid <= s1_valid;

      if (rd_en) begin
        issue_left <= issue_left - CW'(1);
        rd_addr    <= (rd_addr == last_addr) ? '0 : rd_addr + AW'(1);
      end
      if (rd_valid) begin
        k <= k + CW'(1);
      end

      // consume cross-product signs in order
      if (s2_valid) begin
        if ((state == ST_TEST) && !convex_r) begin
          if (s2_cross) begin
            wn <= sg_pos ? wn + WW'(1) : wn - WW'(1);
          end
        end else if (s2_first) begin
          s0_pos <= sg_pos;
          s0_neg <= sg_neg;
        end else if ((s0_pos && sg_neg) || (s0_neg && sg_pos)) begin
          fail <= 1'b1;
        end
      end

      // the finish state decides the output valid on its own
      if (m_axis_tready && (state != ST_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_inside <= 1'b0;
            res_convex <= 1'b0;
            res_status <= STATUS_OK;
            px         <= in_x;
            py         <= in_y;
            state      <= ST_FINISH;
            unique case (op_in)
              OP_CLEAR: cnt <= '0;
              OP_APPEND: begin
                if (cnt < NW'(MAX_VERTICES)) begin
                  cnt <= cnt + NW'(1);
                end else begin
                  res_status <= STATUS_FULL;
                end
              end
              OP_QUERY: begin
                if (cnt < NW'(3)) begin
                  res_status <= STATUS_SHORT;
                end else begin
                  // corners start at v[n-2], v[n-1], v[0]
                  rd_addr    <= AW'(cnt - NW'(2));
                  issue_left <= CW'(cnt) + CW'(2);
                  k          <= '0;
                  fail       <= 1'b0;
                  state      <= ST_CONV;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CONV: begin
          if (drained) begin
            // edges start with the closing edge v[n-1] -> v[0]
            convex_r   <= !fail;
            res_convex <= !fail;
            fail       <= 1'b0;
            wn         <= '0;
            rd_addr    <= last_addr;
            issue_left <= CW'(cnt) + CW'(1);
            k          <= '0;
            state      <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (drained) begin
            res_inside <= convex_r ? !fail : (wn != '0);
            state      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, res_convex, res_inside};
            m_axis_tuser  <= res_status;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!rd_valid && !s1_valid && !s2_valid && (issue_left == '0)))
    else $error("pipeline busy while idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= NW'(MAX_VERTICES))
    else $error("vertex count beyond table size");

  a_read_phase: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> ((state == ST_CONV) || (state == ST_TEST)))
    else $error("cross product outside a query pass");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (NW'(rd_addr) < cnt))
    else $error("read beyond stored vertices");

  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready)) |=> m_axis_tvalid)
    else $error("result not presented");

endmodule
